[hdl/lsl_pkg.sv]
// Shared types, constants and lookup functions of the Pascal subset lexer.
package lsl_pkg;

    localparam int POS_W = 16;
    localparam int MAX_WORD_LEN = 9;
    localparam int WIDX_W = $clog2(MAX_WORD_LEN);
    localparam int NAMED_WORDS = 16;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);

    localparam logic [3:0] MODE_IDLE       = 4'd0;
    localparam logic [3:0] MODE_HELD       = 4'd1;
    localparam logic [3:0] MODE_IDENT      = 4'd2;
    localparam logic [3:0] MODE_NUMBER     = 4'd3;
    localparam logic [3:0] MODE_STRING     = 4'd4;
    localparam logic [3:0] MODE_BRACE      = 4'd5;
    localparam logic [3:0] MODE_PSTAR      = 4'd6;
    localparam logic [3:0] MODE_PSTAR_STAR = 4'd7;

    localparam logic [3:0] K_KEYWORD = 4'd0;
    localparam logic [3:0] K_TYPE    = 4'd1;
    localparam logic [3:0] K_BOOL    = 4'd2;
    localparam logic [3:0] K_OPER    = 4'd3;
    localparam logic [3:0] K_DELIM   = 4'd4;
    localparam logic [3:0] K_IDENT   = 4'd5;
    localparam logic [3:0] K_NUMBER  = 4'd6;
    localparam logic [3:0] K_STRING  = 4'd7;
    localparam logic [3:0] K_UNKNOWN = 4'd8;
    localparam logic [3:0] K_EOF     = 4'd9;

    localparam logic [5:0] IX_NONE   = 6'd0;
    localparam logic [5:0] IX_ASSIGN = 6'd17;
    localparam logic [5:0] IX_EQ     = 6'd18;
    localparam logic [5:0] IX_NE     = 6'd19;
    localparam logic [5:0] IX_LT     = 6'd20;
    localparam logic [5:0] IX_LE     = 6'd21;
    localparam logic [5:0] IX_GT     = 6'd22;
    localparam logic [5:0] IX_GE     = 6'd23;
    localparam logic [5:0] IX_PLUS   = 6'd24;
    localparam logic [5:0] IX_MINUS  = 6'd25;
    localparam logic [5:0] IX_STAR   = 6'd26;
    localparam logic [5:0] IX_SLASH  = 6'd27;
    localparam logic [5:0] IX_RANGE  = 6'd28;
    localparam logic [5:0] IX_SEMI   = 6'd29;
    localparam logic [5:0] IX_COMMA  = 6'd30;
    localparam logic [5:0] IX_COLON  = 6'd31;
    localparam logic [5:0] IX_DOT    = 6'd32;
    localparam logic [5:0] IX_QUOTE  = 6'd33;
    localparam logic [5:0] IX_LPAREN = 6'd34;
    localparam logic [5:0] IX_RPAREN = 6'd35;
    localparam logic [5:0] IX_LAST_KW   = 6'd11;
    localparam logic [5:0] IX_LAST_TYPE = 6'd14;
    localparam logic [5:0] IX_LAST_BOOL = 6'd16;
    localparam logic [5:0] IX_LAST_OPER = 6'd28;

    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_QUOTE  = 8'd39;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_PLUS   = 8'd43;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_DOT    = 8'd46;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_0      = 8'd48;
    localparam logic [7:0] CH_9      = 8'd57;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] CH_SEMI   = 8'd59;
    localparam logic [7:0] CH_LT     = 8'd60;
    localparam logic [7:0] CH_EQ     = 8'd61;
    localparam logic [7:0] CH_GT     = 8'd62;
    localparam logic [7:0] CH_UC_A   = 8'd65;
    localparam logic [7:0] CH_UC_Z   = 8'd90;
    localparam logic [7:0] CH_UNDER  = 8'd95;
    localparam logic [7:0] CH_LC_A   = 8'd97;
    localparam logic [7:0] CH_LC_Z   = 8'd122;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    localparam logic [8*MAX_WORD_LEN-1:0] KW_TEXT [NAMED_WORDS] = '{
        "program", "begin", "end", "var", "procedure", "function", "if", "then",
        "else", "while", "do", "integer", "string", "boolean", "true", "false"
    };
    localparam int KW_LEN [NAMED_WORDS] = '{7, 5, 3, 3, 9, 8, 2, 4, 4, 5, 2, 7, 6, 7, 4, 5};

    typedef logic [MAX_WORD_LEN-1:0][7:0] t_wbuf;

    typedef struct packed {
        logic [3:0]       kind;
        logic [5:0]       idx;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] len;
    } t_res;

    // One queue entry: the results of one input beat, one or two of them.
    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_entry;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v == POS_MAX) ? v : v + POS_ONE;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [3:0] kind_of(input logic [5:0] ix);
        logic [3:0] k;
        if (ix <= IX_LAST_KW) k = K_KEYWORD;
        else if (ix <= IX_LAST_TYPE) k = K_TYPE;
        else if (ix <= IX_LAST_BOOL) k = K_BOOL;
        else if (ix <= IX_LAST_OPER) k = K_OPER;
        else k = K_DELIM;
        return k;
    endfunction

    // Characters that form a symbol alone and are never held.
    function automatic logic [5:0] single_sym(input logic [7:0] c);
        logic [5:0] ix;
        case (c)
            CH_EQ:     ix = IX_EQ;
            CH_PLUS:   ix = IX_PLUS;
            CH_MINUS:  ix = IX_MINUS;
            CH_STAR:   ix = IX_STAR;
            CH_SLASH:  ix = IX_SLASH;
            CH_SEMI:   ix = IX_SEMI;
            CH_COMMA:  ix = IX_COMMA;
            CH_RPAREN: ix = IX_RPAREN;
            default:   ix = IX_NONE;
        endcase
        return ix;
    endfunction

    function automatic logic [5:0] held_sym(input logic [7:0] c);
        logic [5:0] ix;
        case (c)
            CH_COLON:  ix = IX_COLON;
            CH_LT:     ix = IX_LT;
            CH_GT:     ix = IX_GT;
            CH_DOT:    ix = IX_DOT;
            default:   ix = IX_LPAREN;
        endcase
        return ix;
    endfunction

    function automatic logic [5:0] pair_sym(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] ix;
        ix = IX_NONE;
        if (a == CH_COLON && b == CH_EQ) ix = IX_ASSIGN;
        else if (a == CH_LT && b == CH_GT) ix = IX_NE;
        else if (a == CH_LT && b == CH_EQ) ix = IX_LE;
        else if (a == CH_GT && b == CH_EQ) ix = IX_GE;
        else if (a == CH_DOT && b == CH_DOT) ix = IX_RANGE;
        return ix;
    endfunction

    // Whole-word compare against every reserved word in parallel.
    function automatic logic [5:0] kw_lookup(input t_wbuf wb, input logic [POS_W-1:0] len);
        logic [5:0] ix;
        logic       hit;
        ix = IX_NONE;
        for (int i = NAMED_WORDS - 1; i >= 0; i--) begin
            hit = (len == POS_W'(KW_LEN[i]));
            for (int j = 0; j < MAX_WORD_LEN; j++) begin
                if (j < KW_LEN[i]) begin
                    if (wb[j] != KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8]) hit = 1'b0;
                end
            end
            if (hit) ix = 6'(i + 1);
        end
        return ix;
    endfunction

endpackage

[hdl/lsl_front.sv]
// Scanner: tracks mode and position, classifies each character into result entries.
module lsl_front import lsl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_action,
    input  logic [7:0] i_ch,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [3:0]       r_mode, n_mode;
    logic [7:0]       r_held, n_held;
    logic [POS_W-1:0] r_line, n_line, r_col, n_col;
    logic [POS_W-1:0] r_tline, n_tline, r_tcol, n_tcol, r_tlen, n_tlen;
    t_wbuf            r_buf, n_buf;

    logic       f_vld, s_vld;
    t_res       f_res, s_res;
    logic [5:0] kw_ix, pair_ix;
    logic       st_take;

    assign kw_ix   = kw_lookup(r_buf, r_tlen);
    assign pair_ix = pair_sym(r_held, i_ch);

    always_comb begin
        n_mode  = r_mode;
        n_held  = r_held;
        n_line  = r_line;
        n_col   = r_col;
        n_tline = r_tline;
        n_tcol  = r_tcol;
        n_tlen  = r_tlen;
        n_buf   = r_buf;
        f_vld   = 1'b0;
        s_vld   = 1'b0;
        f_res   = '{kind: K_IDENT, idx: IX_NONE, line: r_tline, col: r_tcol, len: r_tlen};
        s_res   = '{kind: K_UNKNOWN, idx: IX_NONE, line: r_line, col: r_col, len: POS_ONE};
        st_take = 1'b0;

        if (i_action) begin
            unique case (r_mode)
                MODE_HELD: begin
                    f_vld = 1'b1;
                    f_res.idx  = held_sym(r_held);
                    f_res.kind = kind_of(f_res.idx);
                    f_res.len  = POS_ONE;
                end
                MODE_IDENT: begin
                    f_vld = 1'b1;
                    if (kw_ix != IX_NONE) begin
                        f_res.idx  = kw_ix;
                        f_res.kind = kind_of(kw_ix);
                    end
                end
                MODE_NUMBER: begin
                    f_vld = 1'b1;
                    f_res.kind = K_NUMBER;
                end
                MODE_STRING: begin
                    f_vld = 1'b1;
                    f_res.kind = K_STRING;
                end
                default: ;
            endcase
            s_vld = 1'b1;
            s_res = '{kind: K_EOF, idx: IX_NONE, line: r_line, col: r_col, len: '0};
            n_mode = MODE_IDLE;
            n_held = '0;
        end else begin
            unique case (r_mode)
                MODE_HELD: begin
                    if (r_held == CH_LPAREN && i_ch == CH_STAR) begin
                        n_mode = MODE_PSTAR;
                    end else if (pair_ix != IX_NONE) begin
                        f_vld = 1'b1;
                        f_res.idx  = pair_ix;
                        f_res.kind = kind_of(pair_ix);
                        f_res.len  = POS_W'(2);
                        n_mode = MODE_IDLE;
                    end else begin
                        f_vld = 1'b1;
                        f_res.idx  = held_sym(r_held);
                        f_res.kind = kind_of(f_res.idx);
                        f_res.len  = POS_ONE;
                        st_take = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha(i_ch) || is_digit(i_ch) || i_ch == CH_UNDER) begin
                        if (r_tlen < POS_W'(MAX_WORD_LEN)) n_buf[r_tlen[WIDX_W-1:0]] = i_ch;
                        n_tlen = sat_inc(r_tlen);
                    end else begin
                        f_vld = 1'b1;
                        if (kw_ix != IX_NONE) begin
                            f_res.idx  = kw_ix;
                            f_res.kind = kind_of(kw_ix);
                        end
                        st_take = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(i_ch)) begin
                        n_tlen = sat_inc(r_tlen);
                    end else begin
                        f_vld = 1'b1;
                        f_res.kind = K_NUMBER;
                        st_take = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (i_ch == CH_QUOTE) begin
                        f_vld = 1'b1;
                        f_res.kind = K_STRING;
                        n_mode = MODE_IDLE;
                    end else begin
                        n_tlen = sat_inc(r_tlen);
                    end
                end
                MODE_BRACE: if (i_ch == CH_RBRACE) n_mode = MODE_IDLE;
                MODE_PSTAR: if (i_ch == CH_STAR) n_mode = MODE_PSTAR_STAR;
                MODE_PSTAR_STAR: begin
                    if (i_ch == CH_RPAREN) n_mode = MODE_IDLE;
                    else if (i_ch != CH_STAR) n_mode = MODE_PSTAR;
                end
                default: st_take = 1'b1;
            endcase

            // open a new token at this character
            if (st_take) begin
                n_tline = r_line;
                n_tcol  = r_col;
                n_mode  = MODE_IDLE;
                if (is_space(i_ch)) begin
                    n_mode = MODE_IDLE;
                end else if (i_ch == CH_LBRACE) begin
                    n_mode = MODE_BRACE;
                end else if (i_ch == CH_QUOTE) begin
                    n_mode = MODE_STRING;
                    n_tlen = '0;
                end else if (is_digit(i_ch)) begin
                    n_mode = MODE_NUMBER;
                    n_tlen = POS_ONE;
                end else if (i_ch == CH_COLON || i_ch == CH_LT || i_ch == CH_GT ||
                             i_ch == CH_DOT || i_ch == CH_LPAREN) begin
                    n_mode = MODE_HELD;
                    n_held = i_ch;
                end else if (single_sym(i_ch) != IX_NONE) begin
                    s_vld = 1'b1;
                    s_res.idx  = single_sym(i_ch);
                    s_res.kind = kind_of(s_res.idx);
                end else if (is_alpha(i_ch) || i_ch == CH_UNDER) begin
                    n_mode   = MODE_IDENT;
                    n_buf[0] = i_ch;
                    n_tlen   = POS_ONE;
                end else begin
                    s_vld = 1'b1;
                end
            end

            if (i_ch == CH_NL) begin
                n_line = sat_inc(r_line);
                n_col  = POS_ONE;
            end else begin
                n_col = sat_inc(r_col);
            end
        end
    end

    assign o_push       = i_accept && (f_vld || s_vld);
    assign o_entry.two  = f_vld && s_vld;
    assign o_entry.r0   = f_vld ? f_res : s_res;
    assign o_entry.r1   = s_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_held  <= '0;
            r_line  <= POS_ONE;
            r_col   <= POS_ONE;
            r_tline <= POS_ONE;
            r_tcol  <= POS_ONE;
            r_tlen  <= '0;
            r_buf   <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_line  <= n_line;
            r_col   <= n_col;
            r_tline <= n_tline;
            r_tcol  <= n_tcol;
            r_tlen  <= n_tlen;
            r_buf   <= n_buf;
        end
    end

endmodule

[hdl/lsl_queue.sv]
// Short queue of result entries between scanner and output stage.
module lsl_queue import lsl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_entry
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + Q_AW'(1);
            if (i_pop)  r_rp <= r_rp + Q_AW'(1);
            if (i_push && !i_pop) r_cnt <= r_cnt + (Q_AW+1)'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - (Q_AW+1)'(1);
        end
    end

endmodule

[hdl/lsl_back.sv]
// Output stage: holds one entry and hands out its results one beat at a time.
module lsl_back import lsl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_empty,
    input  t_entry i_entry,
    output logic   o_pop,
    input  logic   i_stall,
    output logic   o_valid,
    output t_res   o_res,
    output logic   o_last
);

    logic   r_full, r_sel;
    t_entry r_ent;
    logic   done;

    assign o_valid = r_full;
    assign o_res   = r_sel ? r_ent.r1 : r_ent.r0;
    assign o_last  = (r_sel == r_ent.two);
    assign done    = r_full && !i_stall && o_last;
    assign o_pop   = !i_empty && (!r_full || done);

    always_ff @(posedge i_clk) begin
        if (o_pop) r_ent <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_sel  <= 1'b0;
        end else if (o_pop) begin
            r_full <= 1'b1;
            r_sel  <= 1'b0;
        end else if (done) begin
            r_full <= 1'b0;
        end else if (r_full && !i_stall) begin
            r_sel <= 1'b1;
        end
    end

endmodule

[hdl/pascal_subset_lexer_core.sv]
// Pascal subset lexer: one source character per beat in, one token per beat out.
// Takes a character every cycle while the entry queue has room; each character
// or end mark yields zero, one or two tokens, and the output stage delivers one
// token per cycle while not stalled, so a beat that finishes two tokens occupies
// the output for both of them in turn. The four-entry queue between scanner and
// output stage absorbs such bursts and output stalls.
module pascal_subset_lexer_core import lsl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_kind,
    output logic [5:0]  o_word_index,
    output logic [15:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);

    logic   accept, push, pop, q_full, q_empty;
    t_entry f_entry, q_entry;
    t_res   res;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    lsl_front u_front (
        .i_clk, .i_rst_n,
        .i_accept(accept), .i_action, .i_ch,
        .o_push(push), .o_entry(f_entry)
    );

    lsl_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(push), .i_entry(f_entry), .i_pop(pop),
        .o_full(q_full), .o_empty(q_empty), .o_entry(q_entry)
    );

    lsl_back u_back (
        .i_clk, .i_rst_n,
        .i_empty(q_empty), .i_entry(q_entry), .o_pop(pop),
        .i_stall, .o_valid, .o_res(res), .o_last(o_last_of_run)
    );

    assign o_kind         = res.kind;
    assign o_word_index   = res.idx;
    assign o_start_line   = res.line;
    assign o_start_column = res.col;
    assign o_token_length = res.len;

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_empty |-> !pop) else $error("pop from empty queue");
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == K_EOF) |-> o_last_of_run) else $error("eof not last");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the Pascal subset lexer core.
`timescale 1ns / 100ps
module tb_top;
    import lsl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [3:0]  kind;
        logic [5:0]  idx;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic        last;
    } t_token;

    class t_scoreboard;
        t_token      expected_tokens[$];
        t_token      run[$];
        int          errors;
        logic [3:0]  mode;
        logic [7:0]  held;
        int          cur_line, cur_col, tok_line, tok_col, tok_len;
        logic [7:0]  wbuf[MAX_WORD_LEN];
        string       words[NAMED_WORDS];

        function new();
            words = '{"program", "begin", "end", "var", "procedure", "function", "if",
                      "then", "else", "while", "do", "integer", "string", "boolean",
                      "true", "false"};
            mode = MODE_IDLE;
            held = 8'h00;
            cur_line = 1; cur_col = 1; tok_line = 1; tok_col = 1; tok_len = 0;
            foreach (wbuf[i]) wbuf[i] = 8'h00;
            errors = 0;
        endfunction

        function int bump(int v);
            return (v < 65535) ? v + 1 : v;
        endfunction

        function logic [5:0] one_char_sym(logic [7:0] c);
            case (c)
                CH_EQ:     return IX_EQ;
                CH_LT:     return IX_LT;
                CH_GT:     return IX_GT;
                CH_PLUS:   return IX_PLUS;
                CH_MINUS:  return IX_MINUS;
                CH_STAR:   return IX_STAR;
                CH_SLASH:  return IX_SLASH;
                CH_SEMI:   return IX_SEMI;
                CH_COMMA:  return IX_COMMA;
                CH_COLON:  return IX_COLON;
                CH_DOT:    return IX_DOT;
                CH_QUOTE:  return IX_QUOTE;
                CH_LPAREN: return IX_LPAREN;
                CH_RPAREN: return IX_RPAREN;
                default:   return IX_NONE;
            endcase
        endfunction

        function logic [5:0] two_char_sym(logic [7:0] a, logic [7:0] b);
            if (a == CH_COLON && b == CH_EQ) return IX_ASSIGN;
            if (a == CH_LT && b == CH_GT) return IX_NE;
            if (a == CH_LT && b == CH_EQ) return IX_LE;
            if (a == CH_GT && b == CH_EQ) return IX_GE;
            if (a == CH_DOT && b == CH_DOT) return IX_RANGE;
            return IX_NONE;
        endfunction

        function logic [3:0] class_of(logic [5:0] ix);
            if (ix <= IX_LAST_KW) return K_KEYWORD;
            if (ix <= IX_LAST_TYPE) return K_TYPE;
            if (ix <= IX_LAST_BOOL) return K_BOOL;
            if (ix <= IX_LAST_OPER) return K_OPER;
            return K_DELIM;
        endfunction

        function bit is_ws(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
        endfunction

        function void push_token(logic [3:0] k, logic [5:0] ix, int ln, int cl, int len);
            t_token t;
            t.kind = k; t.idx = ix; t.line = ln[15:0]; t.col = cl[15:0];
            t.len = len[15:0]; t.last = 1'b0;
            run.push_back(t);
        endfunction

        function void push_sym(logic [5:0] ix, int len);
            push_token(class_of(ix), ix, tok_line, tok_col, len);
        endfunction

        function void close_word();
            bit hit;
            if (tok_len <= MAX_WORD_LEN) begin
                for (int i = 0; i < NAMED_WORDS; i++) begin
                    hit = (words[i].len() == tok_len);
                    for (int j = 0; j < words[i].len() && hit; j++)
                        if (wbuf[j] != words[i][j]) hit = 0;
                    if (hit) begin
                        push_token(class_of(6'(i + 1)), 6'(i + 1), tok_line, tok_col, tok_len);
                        return;
                    end
                end
            end
            push_token(K_IDENT, IX_NONE, tok_line, tok_col, tok_len);
        endfunction

        function void open_token(logic [7:0] c, int ln, int cl);
            logic [5:0] ix;
            tok_line = ln;
            tok_col = cl;
            mode = MODE_IDLE;
            ix = one_char_sym(c);
            if (is_ws(c)) return;
            if (c == CH_LBRACE) begin
                mode = MODE_BRACE;
            end else if (c == CH_QUOTE) begin
                mode = MODE_STRING;
                tok_len = 0;
            end else if (is_num(c)) begin
                mode = MODE_NUMBER;
                tok_len = 1;
            end else if (c == CH_COLON || c == CH_LT || c == CH_GT || c == CH_DOT ||
                         c == CH_LPAREN) begin
                mode = MODE_HELD;
                held = c;
            end else if (ix != IX_NONE) begin
                push_sym(ix, 1);
            end else if (is_letter(c) || c == CH_UNDER) begin
                mode = MODE_IDENT;
                wbuf[0] = c;
                tok_len = 1;
            end else begin
                push_token(K_UNKNOWN, IX_NONE, ln, cl, 1);
            end
        endfunction

        // Advance the lexer by one accepted beat and queue what it yields.
        function void note_beat(logic act, logic [7:0] c);
            int ln, cl;
            logic [5:0] ix;
            ln = cur_line;
            cl = cur_col;
            run.delete();
            if (act) begin
                case (mode)
                    MODE_HELD:   push_sym(one_char_sym(held), 1);
                    MODE_IDENT:  close_word();
                    MODE_NUMBER: push_token(K_NUMBER, IX_NONE, tok_line, tok_col, tok_len);
                    MODE_STRING: push_token(K_STRING, IX_NONE, tok_line, tok_col, tok_len);
                    default: ;
                endcase
                push_token(K_EOF, IX_NONE, cur_line, cur_col, 0);
                mode = MODE_IDLE;
                held = 8'h00;
            end else begin
                case (mode)
                    MODE_HELD: begin
                        ix = two_char_sym(held, c);
                        if (held == CH_LPAREN && c == CH_STAR) begin
                            mode = MODE_PSTAR;
                        end else if (ix != IX_NONE) begin
                            push_sym(ix, 2);
                            mode = MODE_IDLE;
                        end else begin
                            push_sym(one_char_sym(held), 1);
                            open_token(c, ln, cl);
                        end
                    end
                    MODE_IDENT: begin
                        if (is_letter(c) || is_num(c) || c == CH_UNDER) begin
                            if (tok_len < MAX_WORD_LEN) wbuf[tok_len] = c;
                            tok_len = bump(tok_len);
                        end else begin
                            close_word();
                            open_token(c, ln, cl);
                        end
                    end
                    MODE_NUMBER: begin
                        if (is_num(c)) begin
                            tok_len = bump(tok_len);
                        end else begin
                            push_token(K_NUMBER, IX_NONE, tok_line, tok_col, tok_len);
                            open_token(c, ln, cl);
                        end
                    end
                    MODE_STRING: begin
                        if (c == CH_QUOTE) begin
                            push_token(K_STRING, IX_NONE, tok_line, tok_col, tok_len);
                            mode = MODE_IDLE;
                        end else begin
                            tok_len = bump(tok_len);
                        end
                    end
                    MODE_BRACE: if (c == CH_RBRACE) mode = MODE_IDLE;
                    MODE_PSTAR: if (c == CH_STAR) mode = MODE_PSTAR_STAR;
                    MODE_PSTAR_STAR: begin
                        if (c == CH_RPAREN) mode = MODE_IDLE;
                        else if (c != CH_STAR) mode = MODE_PSTAR;
                    end
                    default: open_token(c, ln, cl);
                endcase
                if (c == CH_NL) begin
                    cur_line = bump(cur_line);
                    cur_col = 1;
                end else begin
                    cur_col = bump(cur_col);
                end
            end
            if (run.size() > 0) run[run.size() - 1].last = 1'b1;
            foreach (run[i]) expected_tokens.push_back(run[i]);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("MISMATCH %s: got %0d, want %0d", what, got, want);
        endtask

        task check_token(t_token got);
            t_token want;
            if (expected_tokens.size() == 0) begin
                report("unexpected token, kind", got.kind, 0);
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind != want.kind) report("kind", got.kind, want.kind);
            if (got.idx != want.idx) report("word_index", got.idx, want.idx);
            if (got.line != want.line) report("start_line", got.line, want.line);
            if (got.col != want.col) report("start_column", got.col, want.col);
            if (got.len != want.len) report("token_length", got.len, want.len);
            if (got.last != want.last) report("last_of_run", got.last, want.last);
        endtask
    endclass

    logic        i_clk, i_rst_n, i_valid, i_action, i_stall;
    logic [7:0]  i_ch;
    logic        o_stall, o_valid, o_last_of_run;
    logic [3:0]  o_kind;
    logic [5:0]  o_word_index;
    logic [15:0] o_start_line, o_start_column, o_token_length;

    t_scoreboard sb;
    logic [8:0]  src[$];
    bit          quiet;
    bit          hold_req;
    int          idle_cycles;

    pascal_subset_lexer_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Monitor both channels and watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_beat(i_action, i_ch);
            if (o_valid && !i_stall)
                sb.check_token('{o_kind, o_word_index, o_start_line, o_start_column,
                                 o_token_length, o_last_of_run});
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Output side: random stall bursts plus a long hold whenever one is requested.
    initial begin
        int hold_cnt, gap;
        hold_cnt = 0;
        gap = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                i_stall <= 1'b1;
                hold_cnt--;
            end else if (gap > 0) begin
                i_stall <= 1'b1;
                gap--;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                i_stall <= 1'b1;
                gap = $urandom_range(0, 4);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_beat(logic act, logic [7:0] c);
        i_valid <= 1'b1;
        i_action <= act;
        i_ch <= c;
        do @(posedge i_clk); while (o_stall);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) src.push_back({1'b0, s[i]});
    endtask

    task automatic add_word();
        string kw[16];
        int n;
        logic [7:0] c;
        kw = '{"program", "begin", "end", "var", "procedure", "function", "if", "then",
               "else", "while", "do", "integer", "string", "boolean", "true", "false"};
        if ($urandom_range(0, 1)) begin
            add_text(kw[$urandom_range(0, 15)]);
        end else begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 5))
                    0: c = 8'($urandom_range(CH_UC_A, CH_UC_Z));
                    1: c = (i == 0) ? CH_UNDER : 8'($urandom_range(CH_0, CH_9));
                    2: c = CH_UNDER;
                    default: c = 8'($urandom_range(CH_LC_A, CH_LC_Z));
                endcase
                src.push_back({1'b0, c});
            end
        end
    endtask

    // Queue one random token-shaped chunk of source text.
    task automatic add_chunk();
        string ops[16];
        int n;
        ops = '{":=", "=", "<>", "<", "<=", ">", ">=", "+", "-", "*", "/", "..",
                ";", ",", ":", ")"};
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: add_word();
            5, 6: begin
                n = $urandom_range(1, 4);
                repeat (n) src.push_back({1'b0, 8'($urandom_range(CH_0, CH_9))});
            end
            7: begin
                src.push_back({1'b0, CH_QUOTE});
                n = $urandom_range(0, 5);
                repeat (n) src.push_back({1'b0, 8'($urandom_range(0, 255))});
                if ($urandom_range(0, 3) != 0) src.push_back({1'b0, CH_QUOTE});
            end
            8, 9, 10: add_text(ops[$urandom_range(0, 15)]);
            11: begin
                src.push_back({1'b0, CH_LBRACE});
                repeat ($urandom_range(0, 4)) src.push_back({1'b0, 8'($urandom_range(0, 255))});
                if ($urandom_range(0, 3) != 0) src.push_back({1'b0, CH_RBRACE});
            end
            12: begin
                add_text("(*");
                repeat ($urandom_range(0, 4))
                    src.push_back({1'b0, $urandom_range(0, 1) ? CH_STAR : 8'($urandom_range(0, 255))});
                if ($urandom_range(0, 3) != 0) add_text("*)");
            end
            13, 14: src.push_back({1'b0, $urandom_range(0, 1) ? CH_NL : CH_SPACE});
            15: src.push_back({1'b0, 8'($urandom_range(0, 255))});
            16: src.push_back({1'b1, 8'($urandom_range(0, 255))});
            17: begin
                add_text(ops[$urandom_range(0, 15)]);
                src.push_back({1'b1, 8'h00});
            end
            default: src.push_back({1'b0, CH_TAB});
        endcase
        if ($urandom_range(0, 2) == 0) src.push_back({1'b0, CH_SPACE});
    endtask

    task automatic drain_queue();
        logic [8:0] b;
        while (src.size() > 0) begin
            b = src.pop_front();
            send_beat(b[8], b[7:0]);
        end
    endtask

    initial begin
        int sent;
        sb = new();
        quiet = 0;
        hold_req = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = 1'b0;
        i_ch = 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: two-char operators, whole-word keywords, comments, odd bytes.
        add_text("x:=1<>2;if(*a*){b}'s'..ifx");
        src.push_back({1'b0, 8'h00});
        src.push_back({1'b0, 8'hFF});
        src.push_back({1'b0, CH_RBRACE});
        add_text("'ab");
        src.push_back({1'b1, 8'h00});
        add_text(">");
        src.push_back({1'b1, 8'h00});
        drain_queue();

        sent = 0;
        while (sent < 300) begin
            add_chunk();
            sent += src.size();
            if (sent > 150 && sent < 170) hold_req = 1;
            if (sent > 260) quiet = 1;
            drain_queue();
        end

        // Long identifiers, a prefix keyword and a trailing end mark, no gaps.
        quiet = 1;
        add_text("' abcdefghijklm 12");
        add_text("do x procedures ");
        src.push_back({1'b1, 8'h00});
        drain_queue();
        i_valid <= 1'b0;

        while (sb.expected_tokens.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_tokens.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
